// File: hdl/ppbf_pkg.sv
// Shared types and constants for the paced playout byte FIFO.
`timescale 1ns / 1ps
`default_nettype none

package ppbf_pkg;

  // Widths fixed by the item and register formats.
  localparam int MODE_W    = 3;
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 15;
  localparam int FILL_W    = 14;
  localparam int STATUS_W  = 2;
  localparam int BPMS_W    = 11;
  localparam int BPBLK_W   = 14;
  localparam int CREDIT_W  = 20;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 14;

  // Item modes.
  localparam logic [MODE_W-1:0] MODE_WRITE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TICK  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FETCH = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FLUSH = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_CREDIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_GRANT  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_MS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_BLOCK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_BYTE    = 2'd2;

  // Register reset values.
  localparam logic [BPMS_W-1:0]  BPMS_RESET    = 11'd16;
  localparam logic [BPBLK_W-1:0] BPBLK_RESET   = 14'd320;
  localparam logic [BYTE_W-1:0]  SILENCE_RESET = 8'd0;

  localparam logic [CREDIT_W-1:0] CREDIT_MAX = '1;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  request_len;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   out_byte;
    logic [LEN_W-1:0]    granted_len;
    logic [LEN_W-1:0]    real_len;
    logic                ready_res;
    logic [STATUS_W-1:0] status;
    logic [FILL_W-1:0]   fill_level;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
    logic load_out;
  } dp_cmd_t;

endpackage

`default_nettype wire

// File: hdl/ppbf_if.sv
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps
`default_nettype none

interface ppbf_in_if;
  import ppbf_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface ppbf_out_if;
  import ppbf_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: hdl/ppbf_ctrl.sv
// Controller: sequences each item through capture, execute and result load.
`timescale 1ns / 1ps
`default_nettype none

module ppbf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ppbf_pkg::dp_cmd_t      cmd
);
  import ppbf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   slot_free;

  // The result register is free when empty or being drained this cycle.
  assign slot_free = !out_valid_r || out_ready;

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign cmd.capture  = (state_r == S_IDLE) && in_valid;
  assign cmd.execute  = (state_r == S_EXEC);
  assign cmd.load_out = (state_r == S_DONE) && slot_free;

  // State and result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/ppbf_datapath.sv
// Datapath: byte ring memory, pointers, credit accounting and result register.
`timescale 1ns / 1ps
`default_nettype none

module ppbf_datapath #(
  parameter int RING_DEPTH = 8192
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire ppbf_pkg::dp_cmd_t              cmd,
  input  wire ppbf_pkg::in_item_t             in_item,
  input  wire logic                           cfg_we,
  input  wire logic [ppbf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ppbf_pkg::CFG_DAT_W-1:0] cfg_data,
  output ppbf_pkg::out_item_t                 out_item
);
  import ppbf_pkg::*;

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam int XW = (CW > LEN_W) ? CW : LEN_W;
  localparam logic [AW-1:0] PTR_LAST = AW'(RING_DEPTH - 1);
  localparam logic [CW-1:0] FILL_FULL = CW'(RING_DEPTH);

  // Configuration registers.
  logic [BPMS_W-1:0]  bpms_r;
  logic [BPBLK_W-1:0] bpblk_r;
  logic [BYTE_W-1:0]  silence_r;

  // Ring and flow state.
  logic [BYTE_W-1:0]   ring_mem [RING_DEPTH];
  logic [BYTE_W-1:0]   rd_data_r;
  logic [AW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0]       fill_r, fill_nxt;
  logic                started_r, started_nxt;
  logic [CREDIT_W-1:0] credit_r, credit_nxt;
  logic [CREDIT_W-1:0] leftover_r, leftover_nxt;
  logic [LEN_W-1:0]    grant_r, grant_nxt;
  logic [LEN_W-1:0]    real_r, real_nxt;

  // Captured item and the partial result of the execute step.
  in_item_t            item_r;
  logic [BYTE_W-1:0]   obyte_r, obyte_nxt;
  logic [LEN_W-1:0]    glen_r, glen_nxt;
  logic [LEN_W-1:0]    rlen_r, rlen_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                rd_ready_r, rd_ready_nxt;
  logic                is_read_r;
  out_item_t           out_r;

  // Arithmetic helpers.
  logic [CREDIT_W:0]   tick_sum;
  logic [CREDIT_W:0]   total;
  logic [CREDIT_W:0]   excess;
  logic [CREDIT_W:0]   post_total;
  logic                post_ready;
  logic [XW-1:0]       fill_x;
  logic [XW-1:0]       glen_x;
  logic                mem_we;
  logic [31:0]         fill_ext;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpms_r    <= BPMS_RESET;
      bpblk_r   <= BPBLK_RESET;
      silence_r <= SILENCE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BYTES_PER_MS:    bpms_r    <= cfg_data[BPMS_W-1:0];
        CFG_BYTES_PER_BLOCK: bpblk_r   <= cfg_data[BPBLK_W-1:0];
        CFG_SILENCE_BYTE:    silence_r <= cfg_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // Ring memory: one write port and one registered read at the read pointer.
  assign mem_we = cmd.execute && (item_r.mode == MODE_WRITE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[wr_ptr_r] <= item_r.data_byte;
    end
    rd_data_r <= ring_mem[rd_ptr_r];
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_item;
    end
  end

  // Execute step: next flow state and the partial result for one item.
  always_comb begin
    rd_ptr_nxt   = rd_ptr_r;
    wr_ptr_nxt   = wr_ptr_r;
    fill_nxt     = fill_r;
    started_nxt  = started_r;
    credit_nxt   = credit_r;
    leftover_nxt = leftover_r;
    grant_nxt    = grant_r;
    real_nxt     = real_r;
    obyte_nxt    = '0;
    glen_nxt     = '0;
    rlen_nxt     = '0;
    status_nxt   = ST_OK;
    rd_ready_nxt = 1'b0;

    tick_sum = {1'b0, credit_r} + (CREDIT_W + 1)'(bpms_r);
    total    = started_r ? ({1'b0, credit_r} + {1'b0, leftover_r}) : '0;
    excess   = total - (CREDIT_W + 1)'(item_r.request_len);
    fill_x   = XW'(fill_r);
    glen_x   = '0;

    unique case (item_r.mode)
      MODE_WRITE: begin
        wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
        if (fill_r == FILL_FULL) begin
          rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
        end else begin
          fill_nxt = fill_r + 1'b1;
        end
      end
      MODE_TICK: begin
        if (started_r) begin
          credit_nxt = tick_sum[CREDIT_W] ? CREDIT_MAX : tick_sum[CREDIT_W-1:0];
        end
      end
      MODE_READ: begin
        // First request starts the clock with empty credit and leftover.
        if (!started_r) begin
          started_nxt  = 1'b1;
          credit_nxt   = '0;
          leftover_nxt = '0;
        end
        rd_ready_nxt = (total >= (CREDIT_W + 1)'(bpblk_r));
        grant_nxt    = '0;
        real_nxt     = '0;
        if (!rd_ready_nxt) begin
          status_nxt = ST_NO_CREDIT;
        end else begin
          credit_nxt = '0;
          if ((CREDIT_W + 1)'(item_r.request_len) > total) begin
            glen_nxt     = LEN_W'(total);
            leftover_nxt = '0;
          end else begin
            glen_nxt     = item_r.request_len;
            leftover_nxt = excess[CREDIT_W] ? CREDIT_MAX : excess[CREDIT_W-1:0];
          end
          glen_x    = XW'(glen_nxt);
          rlen_nxt  = (fill_x < glen_x) ? LEN_W'(fill_x) : glen_nxt;
          grant_nxt = glen_nxt;
          real_nxt  = rlen_nxt;
        end
      end
      MODE_FETCH: begin
        if (grant_r == '0) begin
          status_nxt = ST_NO_GRANT;
        end else begin
          grant_nxt = grant_r - 1'b1;
          if ((real_r != '0) && (fill_r != '0)) begin
            obyte_nxt  = rd_data_r;
            rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
            fill_nxt   = fill_r - 1'b1;
            real_nxt   = real_r - 1'b1;
          end else begin
            real_nxt   = '0;
            obyte_nxt  = silence_r;
            status_nxt = ST_UNDERFLOW;
          end
          glen_nxt = grant_nxt;
          rlen_nxt = real_nxt;
        end
      end
      MODE_FLUSH: begin
        rd_ptr_nxt   = '0;
        wr_ptr_nxt   = '0;
        fill_nxt     = '0;
        started_nxt  = 1'b0;
        credit_nxt   = '0;
        leftover_nxt = '0;
        grant_nxt    = '0;
        real_nxt     = '0;
      end
      default: ;
    endcase
  end

  // Flow state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r   <= '0;
      wr_ptr_r   <= '0;
      fill_r     <= '0;
      started_r  <= 1'b0;
      credit_r   <= '0;
      leftover_r <= '0;
      grant_r    <= '0;
      real_r     <= '0;
    end else if (cmd.execute) begin
      rd_ptr_r   <= rd_ptr_nxt;
      wr_ptr_r   <= wr_ptr_nxt;
      fill_r     <= fill_nxt;
      started_r  <= started_nxt;
      credit_r   <= credit_nxt;
      leftover_r <= leftover_nxt;
      grant_r    <= grant_nxt;
      real_r     <= real_nxt;
    end
  end

  // Partial result of the execute step.
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      obyte_r    <= obyte_nxt;
      glen_r     <= glen_nxt;
      rlen_r     <= rlen_nxt;
      status_r   <= status_nxt;
      rd_ready_r <= rd_ready_nxt;
      is_read_r  <= (item_r.mode == MODE_READ);
    end
  end

  // Readiness after the item, taken from the updated credit registers.
  assign post_total = {1'b0, credit_r} + {1'b0, leftover_r};
  assign post_ready = (post_total >= (CREDIT_W + 1)'(bpblk_r));
  assign fill_ext   = 32'(fill_r);

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.out_byte    <= obyte_r;
      out_r.granted_len <= glen_r;
      out_r.real_len    <= rlen_r;
      out_r.ready_res   <= is_read_r ? rd_ready_r : post_ready;
      out_r.status      <= status_r;
      out_r.fill_level  <= fill_ext[FILL_W-1:0];
    end
  end

  assign out_item = out_r;

endmodule

`default_nettype wire

// File: hdl/paced_playout_byte_fifo.sv
// Top level of the paced playout byte FIFO.
// Byte ring buffer drained at a real-time pace. Each input beat carries one
// item (write, tick, read request, fetch or flush) and yields exactly one
// result beat. Each item steps in order through accept, execute against
// the registered ring read, and load of the result register; the result
// register lets the next item be accepted while a result beat still waits,
// and a stalled result holds the controller in its last step. The ring is a
// single memory of RING_DEPTH bytes with one write and one registered read
// per cycle; it is not cleared after reset, so no clearing pass is needed
// and the block accepts items right after reset. The user must write the
// configuration registers through cfg_we/cfg_index/cfg_data only while no
// item is in flight; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module paced_playout_byte_fifo #(
  parameter int RING_DEPTH = 8192
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  ppbf_in_if.sink                             in_bus,
  ppbf_out_if.source                          out_bus,
  input  wire logic                           cfg_we,
  input  wire logic [ppbf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ppbf_pkg::CFG_DAT_W-1:0] cfg_data
);
  import ppbf_pkg::*;

  dp_cmd_t   cmd;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_item;

  // Controller.
  ppbf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_bus.ready),
    .cmd       (cmd)
  );

  // Datapath.
  ppbf_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_bus.payload),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_item  (out_item)
  );

  assign in_bus.ready    = in_ready;
  assign out_bus.valid   = out_valid;
  assign out_bus.payload = out_item;

endmodule

`default_nettype wire
